/* rtl/core/csc_pkg.sv */
// ----------------------------------------------------------------------------
// csc_pkg
// Shared codes and types for the CSR subgraph compactor.
// ----------------------------------------------------------------------------
package csc_pkg;

  // command codes
  typedef enum logic [2:0] {
    FN_WRITE   = 3'd0,
    FN_READ    = 3'd1,
    FN_CLEAR   = 3'd2,
    FN_MARK    = 3'd3,
    FN_RENUM   = 3'd4,
    FN_REBUILD = 3'd5
  } func_t;

  // store selectors
  localparam logic [2:0] SP_SEL  = 3'd0;
  localparam logic [2:0] SP_INV  = 3'd1;
  localparam logic [2:0] SP_NID  = 3'd2;
  localparam logic [2:0] SP_RS   = 3'd3;
  localparam logic [2:0] SP_NBR  = 3'd4;
  localparam logic [2:0] SP_ORS  = 3'd5;
  localparam logic [2:0] SP_ONBR = 3'd6;
  localparam logic [2:0] SP_ROOT = 3'd7;

  // status codes
  localparam logic [1:0] STS_OK  = 2'd0;
  localparam logic [1:0] STS_BAD = 2'd1;
  localparam logic [1:0] STS_OVF = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_FIRST = 2'd0;
  localparam logic [1:0] CFG_COUNT = 2'd1;
  localparam logic [1:0] CFG_ROOTS = 2'd2;
  localparam logic [1:0] CFG_BASE  = 2'd3;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_READ,
    S_RUN0,
    S_BASE,
    S_VTX,
    S_VB,
    S_VE,
    S_VMAP,
    S_EDGE,
    S_NB,
    S_NBW,
    S_RN_W,
    S_RN_LD,
    S_RN_BIT,
    S_RT,
    S_RT_LD,
    S_RT_WR
  } state_t;

endpackage

/* rtl/core/csr_subgraph_compactor.sv */
// ----------------------------------------------------------------------------
// csr_subgraph_compactor
// Command-driven graph store with mark, renumber and CSR rebuild runs.
// ----------------------------------------------------------------------------
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------
//  in      | in_func in_space in_index in_data       | start & !busy
//  out     | out_read_value out_out_rows out_out_edges| out_valid strobe
//          | out_status                              |
//  cfg     | cfg_index cfg_data                      | cfg_valid & cfg_ready
//
// A write, clear, unused code or out-of-range read is answered from idle;
// another read first passes S_READ for the registered memory data. Runs
// walk the stores through the single read port of each memory: mark and
// rebuild step by vertex and edge, renumber by bit of each bitmap word,
// then by root. busy is high while a command is in work. Reset clears the
// state, the configuration, the totals and the involvement valid bits; no
// clearing pass. The receiver cannot stall; a result is shown for one cycle.
module csr_subgraph_compactor #(
  parameter int NODES = 4096,
  parameter int EDGES = 16384,
  parameter int ROOTS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_func,
  input  logic [2:0]  in_space,
  input  logic [13:0] in_index,
  input  logic [31:0] in_data,
  output logic        out_valid,
  output logic [31:0] out_read_value,
  output logic [12:0] out_out_rows,
  output logic [14:0] out_out_edges,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import csc_pkg::*;

  localparam int MAPW = (NODES + 31) / 32;
  localparam int MAW  = (MAPW > 1) ? $clog2(MAPW) : 1;
  localparam int NW   = $clog2(NODES);
  localparam int EW   = $clog2(EDGES);
  localparam int RW   = (ROOTS > 1) ? $clog2(ROOTS) : 1;
  localparam int RCW  = $clog2(NODES + 1);
  localparam int ECW  = $clog2(EDGES + 1);

  // configuration
  logic [11:0] first_vertex_r;
  logic [12:0] vertex_count_r;
  logic [8:0]  root_count_r;
  logic [31:0] edge_base_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_vertex_r <= '0;
      vertex_count_r <= '0;
      root_count_r   <= '0;
      edge_base_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIRST: first_vertex_r <= cfg_data[11:0];
        CFG_COUNT: vertex_count_r <= cfg_data[12:0];
        CFG_ROOTS: root_count_r   <= cfg_data[8:0];
        CFG_BASE:  edge_base_r    <= cfg_data;
        default:   ;
      endcase
    end
  end

  // memory ports
  logic           sel_we;  logic [MAW-1:0] sel_wa, sel_ra;  logic [31:0] sel_wd, sel_q;
  logic           inv_we;  logic [MAW-1:0] inv_wa, inv_ra;  logic [31:0] inv_wd, inv_raw_q;
  logic           inv_vq,  inv_clr;
  logic           nid_we;  logic [NW-1:0]  nid_wa, nid_ra;  logic [11:0] nid_wd, nid_q;
  logic           rs_we;   logic [EW-1:0]  rs_wa, rs_ra;    logic [31:0] rs_wd, rs_q;
  logic           nbr_we;  logic [EW-1:0]  nbr_wa, nbr_ra;  logic [11:0] nbr_wd, nbr_q;
  logic           ors_we;  logic [NW-1:0]  ors_wa, ors_ra;  logic [31:0] ors_wd, ors_q;
  logic           onbr_we; logic [EW-1:0]  onbr_wa, onbr_ra; logic [11:0] onbr_wd, onbr_q;
  logic           root_we; logic [RW-1:0]  root_wa, root_ra; logic [11:0] root_wd, root_q;

  logic [31:0] sel_mem  [MAPW];
  logic [31:0] inv_mem  [MAPW];
  logic [MAPW-1:0] inv_vld_r;
  logic [11:0] nid_mem  [NODES];
  logic [31:0] rs_mem   [EDGES];
  logic [11:0] nbr_mem  [EDGES];
  logic [31:0] ors_mem  [NODES];
  logic [11:0] onbr_mem [EDGES];
  logic [11:0] root_mem [ROOTS];

  always_ff @(posedge clk) begin
    if (sel_we) sel_mem[sel_wa] <= sel_wd;
    sel_q <= sel_mem[sel_ra];
  end

  always_ff @(posedge clk) begin
    if (inv_we) inv_mem[inv_wa] <= inv_wd;
    inv_raw_q <= inv_mem[inv_ra];
    inv_vq    <= inv_vld_r[inv_ra];
  end

  // involvement valid bits: an invalid word reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || inv_clr) begin
      inv_vld_r <= '0;
    end else if (inv_we) begin
      inv_vld_r[inv_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (nid_we) nid_mem[nid_wa] <= nid_wd;
    nid_q <= nid_mem[nid_ra];
  end

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[rs_wa] <= rs_wd;
    rs_q <= rs_mem[rs_ra];
  end

  always_ff @(posedge clk) begin
    if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
    nbr_q <= nbr_mem[nbr_ra];
  end

  always_ff @(posedge clk) begin
    if (ors_we) ors_mem[ors_wa] <= ors_wd;
    ors_q <= ors_mem[ors_ra];
  end

  always_ff @(posedge clk) begin
    if (onbr_we) onbr_mem[onbr_wa] <= onbr_wd;
    onbr_q <= onbr_mem[onbr_ra];
  end

  always_ff @(posedge clk) begin
    if (root_we) root_mem[root_wa] <= root_wd;
    root_q <= root_mem[root_ra];
  end

  logic [31:0] inv_q;
  assign inv_q = inv_vq ? inv_raw_q : 32'd0;

  // sequencer registers
  state_t      state_r, state_nxt;
  func_t       func_r, func_nxt;
  logic [2:0]  space_r, space_nxt;
  logic        bad_r, bad_nxt, ovf_r, ovf_nxt;
  logic [12:0] i_r, i_nxt;
  logic [31:0] base_r, base_nxt, b_r, b_nxt, e_r, e_nxt, j_r, j_nxt;
  logic [11:0] nb_r, nb_nxt;
  logic [RCW-1:0] rows_r, rows_nxt;
  logic [ECW-1:0] edges_r, edges_nxt;
  logic [8:0]  w_r, w_nxt;
  logic [4:0]  bit_r, bit_nxt;
  logic [31:0] word_r, word_nxt;
  logic [11:0] next_r, next_nxt;
  logic [12:0] row_total_r, row_total_nxt;
  logic [14:0] edge_total_r, edge_total_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_value_r, out_value_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic        rsp;

  // shared conditions
  logic [31:0] v32, depth, rn_addr;
  logic        oob, i_done, vtx_bad, sel_bit, inv_bit;
  logic        edge_end, edge_bad, edge_full, nb_bad, rt_done, is_mark;
  logic [MAW-1:0] vword;
  logic [8:0]  words;

  assign v32       = 32'(first_vertex_r) + 32'(i_r);
  assign vword     = MAW'(v32 >> 5);
  assign vtx_bad   = (v32 >= NODES) || ((32'(i_r) + 32'd1) >= EDGES);
  assign i_done    = 32'(i_r) >= 32'(vertex_count_r);
  assign sel_bit   = sel_q[v32[4:0]];
  assign inv_bit   = inv_q[v32[4:0]];
  assign is_mark   = (func_r == FN_MARK);
  assign edge_end  = j_r >= e_r;
  assign edge_bad  = j_r >= EDGES;
  assign edge_full = !is_mark && (32'(edges_r) >= EDGES);
  assign nb_bad    = 32'(nbr_q) >= NODES;
  assign words     = 9'((14'(vertex_count_r) + 14'd31) >> 5);
  assign rn_addr   = 32'({w_r, bit_r});
  assign rt_done   = 32'(i_r) >= 32'(root_count_r);

  always_comb begin
    case (in_space)
      SP_SEL, SP_INV: depth = 32'(MAPW);
      SP_NID, SP_ORS: depth = 32'(NODES);
      SP_ROOT:        depth = 32'(ROOTS);
      default:        depth = 32'(EDGES);
    endcase
  end
  assign oob = 32'(in_index) >= depth;

  // next state and datapath registers
  always_comb begin
    state_nxt      = state_r;
    func_nxt       = func_r;
    space_nxt      = space_r;
    bad_nxt        = bad_r;
    ovf_nxt        = ovf_r;
    i_nxt          = i_r;
    base_nxt       = base_r;
    b_nxt          = b_r;
    e_nxt          = e_r;
    j_nxt          = j_r;
    nb_nxt         = nb_r;
    rows_nxt       = rows_r;
    edges_nxt      = edges_r;
    w_nxt          = w_r;
    bit_nxt        = bit_r;
    word_nxt       = word_r;
    next_nxt       = next_r;
    row_total_nxt  = row_total_r;
    edge_total_nxt = edge_total_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    rsp            = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt      = func_t'(in_func);
          space_nxt     = in_space;
          bad_nxt       = 1'b0;
          ovf_nxt       = 1'b0;
          out_value_nxt = 32'd0;
          case (func_t'(in_func))
            FN_WRITE: begin
              bad_nxt = oob;
              rsp     = 1'b1;
            end
            FN_READ: begin
              if (oob) begin
                bad_nxt = 1'b1;
                rsp     = 1'b1;
              end else begin
                state_nxt = S_READ;
              end
            end
            FN_CLEAR: rsp = 1'b1;
            FN_MARK, FN_REBUILD: begin
              rows_nxt  = '0;
              edges_nxt = '0;
              state_nxt = S_RUN0;
            end
            FN_RENUM: begin
              w_nxt     = '0;
              next_nxt  = '0;
              state_nxt = S_RN_W;
            end
            default: rsp = 1'b1;
          endcase
        end
      end
      S_READ: begin
        case (space_r)
          SP_SEL:  out_value_nxt = sel_q;
          SP_INV:  out_value_nxt = inv_q;
          SP_NID:  out_value_nxt = 32'(nid_q);
          SP_RS:   out_value_nxt = rs_q;
          SP_NBR:  out_value_nxt = 32'(nbr_q);
          SP_ORS:  out_value_nxt = ors_q;
          SP_ONBR: out_value_nxt = 32'(onbr_q);
          default: out_value_nxt = 32'(root_q);
        endcase
        rsp       = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RUN0: state_nxt = S_BASE;
      S_BASE: begin
        base_nxt  = rs_q;
        i_nxt     = '0;
        state_nxt = S_VTX;
      end
      S_VTX: begin
        if (i_done) begin
          if (!is_mark) begin
            row_total_nxt  = 13'(rows_r);
            edge_total_nxt = 15'(edges_r);
          end
          rsp       = 1'b1;
          state_nxt = S_IDLE;
        end else if (vtx_bad) begin
          bad_nxt = 1'b1;
          i_nxt   = i_r + 13'd1;
        end else begin
          state_nxt = S_VB;
        end
      end
      S_VB: begin
        b_nxt     = rs_q - base_r;
        state_nxt = S_VE;
      end
      S_VE: begin
        e_nxt     = rs_q - base_r;
        j_nxt     = b_r;
        state_nxt = S_VMAP;
      end
      S_VMAP: begin
        if (is_mark) begin
          if (sel_bit) begin
            state_nxt = S_EDGE;
          end else begin
            i_nxt     = i_r + 13'd1;
            state_nxt = S_VTX;
          end
        end else begin
          if (inv_bit && (32'(rows_r) < NODES)) rows_nxt = rows_r + RCW'(1);
          if (inv_bit && sel_bit) begin
            state_nxt = S_EDGE;
          end else begin
            i_nxt     = i_r + 13'd1;
            state_nxt = S_VTX;
          end
        end
      end
      S_EDGE: begin
        if (edge_end || edge_bad || edge_full) begin
          if (!edge_end && edge_bad) bad_nxt = 1'b1;
          if (!edge_end && !edge_bad) ovf_nxt = 1'b1;
          i_nxt     = i_r + 13'd1;
          state_nxt = S_VTX;
        end else begin
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        nb_nxt = nbr_q;
        if (nb_bad) begin
          bad_nxt = 1'b1;
          j_nxt   = j_r + 32'd1;
          if (!is_mark) edges_nxt = edges_r + ECW'(1);
          state_nxt = S_EDGE;
        end else begin
          state_nxt = S_NBW;
        end
      end
      S_NBW: begin
        if (!is_mark) edges_nxt = edges_r + ECW'(1);
        j_nxt     = j_r + 32'd1;
        state_nxt = S_EDGE;
      end
      S_RN_W: begin
        if (w_r >= words) begin
          i_nxt     = '0;
          state_nxt = S_RT;
        end else if (32'(w_r) >= MAPW) begin
          bad_nxt   = 1'b1;
          i_nxt     = '0;
          state_nxt = S_RT;
        end else begin
          state_nxt = S_RN_LD;
        end
      end
      S_RN_LD: begin
        word_nxt  = inv_q;
        bit_nxt   = '0;
        state_nxt = S_RN_BIT;
      end
      S_RN_BIT: begin
        if (word_r[bit_r]) next_nxt = next_r + 12'd1;
        if (bit_r == 5'd31) begin
          w_nxt     = w_r + 9'd1;
          state_nxt = S_RN_W;
        end else begin
          bit_nxt = bit_r + 5'd1;
        end
      end
      S_RT: begin
        if (rt_done) begin
          rsp       = 1'b1;
          state_nxt = S_IDLE;
        end else if (32'(i_r) >= ROOTS) begin
          bad_nxt   = 1'b1;
          rsp       = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RT_LD;
        end
      end
      S_RT_LD: begin
        if (32'(root_q) >= NODES) begin
          bad_nxt   = 1'b1;
          i_nxt     = i_r + 13'd1;
          state_nxt = S_RT;
        end else begin
          state_nxt = S_RT_WR;
        end
      end
      S_RT_WR: begin
        i_nxt     = i_r + 13'd1;
        state_nxt = S_RT;
      end
      default: state_nxt = S_IDLE;
    endcase
    // result word
    if (rsp) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ovf_nxt ? STS_OVF : (bad_nxt ? STS_BAD : STS_OK);
    end
  end

  // memory controls
  always_comb begin
    sel_we = 1'b0;  sel_wa = '0;  sel_wd = in_data;        sel_ra = '0;
    inv_we = 1'b0;  inv_wa = '0;  inv_wd = in_data;        inv_ra = '0;
    inv_clr = 1'b0;
    nid_we = 1'b0;  nid_wa = '0;  nid_wd = in_data[11:0];  nid_ra = '0;
    rs_we  = 1'b0;  rs_wa  = '0;  rs_wd  = in_data;        rs_ra  = '0;
    nbr_we = 1'b0;  nbr_wa = '0;  nbr_wd = in_data[11:0];  nbr_ra = '0;
    ors_we = 1'b0;  ors_wa = '0;  ors_wd = in_data;        ors_ra = '0;
    onbr_we = 1'b0; onbr_wa = '0; onbr_wd = in_data[11:0]; onbr_ra = '0;
    root_we = 1'b0; root_wa = '0; root_wd = in_data[11:0]; root_ra = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          sel_wa  = MAW'(in_index);  sel_ra  = MAW'(in_index);
          inv_wa  = MAW'(in_index);  inv_ra  = MAW'(in_index);
          nid_wa  = NW'(in_index);   nid_ra  = NW'(in_index);
          rs_wa   = EW'(in_index);   rs_ra   = EW'(in_index);
          nbr_wa  = EW'(in_index);   nbr_ra  = EW'(in_index);
          ors_wa  = NW'(in_index);   ors_ra  = NW'(in_index);
          onbr_wa = EW'(in_index);   onbr_ra = EW'(in_index);
          root_wa = RW'(in_index);   root_ra = RW'(in_index);
          if (func_t'(in_func) == FN_CLEAR) inv_clr = 1'b1;
          if ((func_t'(in_func) == FN_WRITE) && !oob) begin
            case (in_space)
              SP_SEL:  sel_we  = 1'b1;
              SP_INV:  inv_we  = 1'b1;
              SP_NID:  nid_we  = 1'b1;
              SP_RS:   rs_we   = 1'b1;
              SP_NBR:  nbr_we  = 1'b1;
              SP_ORS:  ors_we  = 1'b1;
              SP_ONBR: onbr_we = 1'b1;
              default: root_we = 1'b1;
            endcase
          end
        end
      end
      S_VTX: rs_ra = EW'(i_r);
      S_VB:  rs_ra = EW'(32'(i_r) + 32'd1);
      S_VE: begin
        sel_ra = vword;
        inv_ra = vword;
      end
      S_VMAP: begin
        if (is_mark) begin
          inv_we = sel_bit;
          inv_wa = vword;
          inv_wd = inv_q | (32'd1 << v32[4:0]);
        end else begin
          ors_we = inv_bit && (32'(rows_r) < NODES);
          ors_wa = NW'(rows_r);
          ors_wd = 32'(edges_r) + edge_base_r;
        end
      end
      S_EDGE: nbr_ra = EW'(j_r);
      S_NB: begin
        inv_ra  = MAW'(nbr_q >> 5);
        nid_ra  = NW'(nbr_q);
        onbr_we = nb_bad && !is_mark;
        onbr_wa = EW'(edges_r);
        onbr_wd = 12'd0;
      end
      S_NBW: begin
        if (is_mark) begin
          inv_we = 1'b1;
          inv_wa = MAW'(nb_r >> 5);
          inv_wd = inv_q | (32'd1 << nb_r[4:0]);
        end else begin
          onbr_we = 1'b1;
          onbr_wa = EW'(edges_r);
          onbr_wd = nid_q;
        end
      end
      S_RN_W: inv_ra = MAW'(w_r);
      S_RN_BIT: begin
        nid_we = word_r[bit_r] && (rn_addr < NODES);
        nid_wa = NW'(rn_addr);
        nid_wd = next_r;
      end
      S_RT:    root_ra = RW'(i_r);
      S_RT_LD: nid_ra  = NW'(root_q);
      S_RT_WR: begin
        root_we = 1'b1;
        root_wa = RW'(i_r);
        root_wd = nid_q;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      row_total_r  <= '0;
      edge_total_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      row_total_r  <= row_total_nxt;
      edge_total_r <= edge_total_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    space_r      <= space_nxt;
    bad_r        <= bad_nxt;
    ovf_r        <= ovf_nxt;
    i_r          <= i_nxt;
    base_r       <= base_nxt;
    b_r          <= b_nxt;
    e_r          <= e_nxt;
    j_r          <= j_nxt;
    nb_r         <= nb_nxt;
    rows_r       <= rows_nxt;
    edges_r      <= edges_nxt;
    w_r          <= w_nxt;
    bit_r        <= bit_nxt;
    word_r       <= word_nxt;
    next_r       <= next_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_out_rows   = row_total_r;
  assign out_out_edges  = edge_total_r;
  assign out_status     = out_status_r;

`ifndef ASSERT_OFF
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy)
    else $error("busy after reset");
  a_ovf_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STS_OVF)) |-> (func_r == FN_REBUILD))
    else $error("overflow outside rebuild");
  a_onbr_room: assert property (@(posedge clk) disable iff (!rst_n)
    (onbr_we && (state_r != S_IDLE)) |-> (32'(edges_r) < EDGES))
    else $error("neighbor write beyond edge store");
  a_no_rmw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NBW) |-> $past(state_r) == S_NB)
    else $error("write-back without read");
`endif

endmodule

/* test/csr_subgraph_compactor_test.sv */
// ----------------------------------------------------------------------------
// csr_subgraph_compactor_test
// Checks store access, mark, renumber and rebuild runs against a shadow
// graph model. Every command word gets its one expected result; results
// are compared field by field in order. Directed cases come first, then
// random traffic in phases with and without sender gaps.
// ----------------------------------------------------------------------------
module csr_subgraph_compactor_test;
  import csc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_NODES = 4096;
  localparam int N_EDGES = 16384;
  localparam int N_ROOTS = 256;
  localparam int N_WORDS = N_NODES / 32;

  typedef struct packed {
    logic [2:0]  fn;
    logic [2:0]  sp;
    logic [13:0] idx;
    logic [31:0] data;
  } cmd_t;

  typedef struct packed {
    logic [31:0] rv;
    logic [12:0] rows;
    logic [14:0] edges;
    logic [1:0]  st;
  } result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_func;
  logic [2:0]  in_space;
  logic [13:0] in_index;
  logic [31:0] in_data;
  logic        out_valid;
  logic [31:0] out_read_value;
  logic [12:0] out_out_rows;
  logic [14:0] out_out_edges;
  logic [1:0]  out_status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  csr_subgraph_compactor dut (.*);

  // shadow copy of the graph stores
  logic [31:0] sel_v  [N_WORDS];
  logic [31:0] inv_v  [N_WORDS];
  logic [11:0] nid_v  [N_NODES];
  logic [31:0] row_v  [N_EDGES];
  logic [11:0] nbr_v  [N_EDGES];
  logic [31:0] orow_v [N_NODES];
  logic [11:0] onbr_v [N_EDGES];
  logic [11:0] root_v [N_ROOTS];
  bit          known  [8][N_EDGES];
  logic [12:0] rows_total;
  logic [14:0] edges_total;

  logic [11:0] reg_first;
  logic [12:0] reg_count;
  logic [8:0]  reg_roots;
  logic [31:0] reg_base;

  // probe mode: walk a command without changing state, flag unwritten reads
  bit probing;
  bit undef_hit;
  bit bad, ovf;

  result_t pending [$];
  result_t want_r, got_r;
  int      errors;
  int      gap_pct;

  // ---------------------------------------------------------------------------
  // store helpers
  function automatic int depth_of(logic [2:0] sp);
    case (sp)
      SP_SEL, SP_INV: return N_WORDS;
      SP_NID, SP_ORS: return N_NODES;
      SP_ROOT:        return N_ROOTS;
      default:        return N_EDGES;
    endcase
  endfunction

  function automatic logic [31:0] peek(logic [2:0] sp, int unsigned ix);
    if (!known[sp][ix]) undef_hit = 1'b1;
    case (sp)
      SP_SEL:  return sel_v[ix];
      SP_INV:  return inv_v[ix];
      SP_NID:  return {20'd0, nid_v[ix]};
      SP_RS:   return row_v[ix];
      SP_NBR:  return {20'd0, nbr_v[ix]};
      SP_ORS:  return orow_v[ix];
      SP_ONBR: return {20'd0, onbr_v[ix]};
      default: return {20'd0, root_v[ix]};
    endcase
  endfunction

  function automatic void poke(logic [2:0] sp, int unsigned ix, logic [31:0] val);
    if (probing) return;
    known[sp][ix] = 1'b1;
    case (sp)
      SP_SEL:  sel_v[ix] = val;
      SP_INV:  inv_v[ix] = val;
      SP_NID:  nid_v[ix] = val[11:0];
      SP_RS:   row_v[ix] = val;
      SP_NBR:  nbr_v[ix] = val[11:0];
      SP_ORS:  orow_v[ix] = val;
      SP_ONBR: onbr_v[ix] = val[11:0];
      default: root_v[ix] = val[11:0];
    endcase
  endfunction

  function automatic bit map_bit(logic [2:0] sp, logic [31:0] v);
    logic [31:0] w;
    w = peek(sp, v >> 5);
    return w[v[4:0]];
  endfunction

  function automatic void set_involved(logic [31:0] v);
    poke(SP_INV, v >> 5, peek(SP_INV, v >> 5) | (32'd1 << v[4:0]));
  endfunction

  // edge range of partition vertex i, or 0 when the vertex is skipped
  function automatic bit row_span(logic [31:0] i, output logic [31:0] v,
                                  output logic [31:0] b, output logic [31:0] e);
    logic [31:0] base;
    base = peek(SP_RS, 0);
    v = reg_first + i;
    b = 0;
    e = 0;
    if (v >= N_NODES || i + 1 >= N_EDGES) begin
      bad = 1'b1;
      return 0;
    end
    b = peek(SP_RS, i) - base;
    e = peek(SP_RS, i + 1) - base;
    return 1;
  endfunction

  // ---------------------------------------------------------------------------
  // runs
  function automatic void mark_run();
    logic [31:0] i, v, b, e, j;
    for (i = 0; i < reg_count; i++) begin
      if (!row_span(i, v, b, e)) continue;
      if (!map_bit(SP_SEL, v)) continue;
      set_involved(v);
      for (j = b; j < e; j++) begin
        if (j >= N_EDGES) begin
          bad = 1'b1;
          break;
        end
        set_involved(peek(SP_NBR, j));
      end
    end
  endfunction

  function automatic void renumber_run();
    logic [31:0] words, next, w, i, word, r;
    int b;
    words = (reg_count + 32'd31) >> 5;
    next = 0;
    for (w = 0; w < words; w++) begin
      if (w >= N_WORDS) begin
        bad = 1'b1;
        break;
      end
      word = peek(SP_INV, w);
      for (b = 0; b < 32; b++)
        if (word[b]) begin
          poke(SP_NID, (w << 5) | b, next);
          next++;
        end
    end
    for (i = 0; i < reg_roots; i++) begin
      if (i >= N_ROOTS) begin
        bad = 1'b1;
        break;
      end
      r = peek(SP_ROOT, i);
      poke(SP_ROOT, i, peek(SP_NID, r));
    end
  endfunction

  function automatic void rebuild_run();
    logic [31:0] rows, edges, i, v, b, e, j;
    rows = 0;
    edges = 0;
    for (i = 0; i < reg_count; i++) begin
      if (!row_span(i, v, b, e)) continue;
      if (!map_bit(SP_INV, v)) continue;
      if (rows < N_NODES) begin
        poke(SP_ORS, rows, edges + reg_base);
        rows++;
      end
      if (!map_bit(SP_SEL, v)) continue;
      for (j = b; j < e; j++) begin
        if (j >= N_EDGES) begin
          bad = 1'b1;
          break;
        end
        if (edges >= N_EDGES) begin
          ovf = 1'b1;
          break;
        end
        poke(SP_ONBR, edges, peek(SP_NID, peek(SP_NBR, j)));
        edges++;
      end
    end
    if (!probing) begin
      rows_total = rows[12:0];
      edges_total = edges[14:0];
    end
  endfunction

  // expected result of one command word; advances the shadow state
  function automatic result_t compact_result(cmd_t c);
    result_t r;
    logic [31:0] mask;
    int w;
    bad = 1'b0;
    ovf = 1'b0;
    r.rv = 0;
    mask = (c.sp == SP_SEL || c.sp == SP_INV || c.sp == SP_RS || c.sp == SP_ORS)
           ? 32'hFFFF_FFFF : 32'h0000_0FFF;
    case (c.fn)
      FN_WRITE:
        if (c.idx < depth_of(c.sp)) poke(c.sp, c.idx, c.data & mask);
        else bad = 1'b1;
      FN_READ:
        if (c.idx < depth_of(c.sp)) r.rv = peek(c.sp, c.idx) & mask;
        else bad = 1'b1;
      FN_CLEAR:
        for (w = 0; w < N_WORDS; w++) poke(SP_INV, w, 32'd0);
      FN_MARK:    mark_run();
      FN_RENUM:   renumber_run();
      FN_REBUILD: rebuild_run();
      default: ;
    endcase
    r.rows = rows_total;
    r.edges = edges_total;
    r.st = ovf ? STS_OVF : (bad ? STS_BAD : STS_OK);
    return r;
  endfunction

  function automatic cmd_t mk(logic [2:0] fn, logic [2:0] sp, int unsigned idx,
                              logic [31:0] data);
    cmd_t c;
    c.fn = fn;
    c.sp = sp;
    c.idx = idx[13:0];
    c.data = data;
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  task automatic send_word(cmd_t c);
    result_t r;
    r = compact_result(c);
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start    <= 1'b1;
    in_func  <= c.fn;
    in_space <= c.sp;
    in_index <= c.idx;
    in_data  <= c.data;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending.push_back(r);
  endtask

  // unwritten entries are never read: a read of one becomes a write,
  // a run that would touch one is dropped
  task automatic issue(cmd_t c);
    result_t r;
    undef_hit = 1'b0;
    probing = 1'b1;
    r = compact_result(c);
    probing = 1'b0;
    if (undef_hit) begin
      if (c.fn != FN_READ) return;
      c.fn = FN_WRITE;
    end
    send_word(c);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic set_reg(logic [1:0] ix, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= ix;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (ix)
      CFG_FIRST: reg_first = val[11:0];
      CFG_COUNT: reg_count = val[12:0];
      CFG_ROOTS: reg_roots = val[8:0];
      default:   reg_base  = val;
    endcase
  endtask

  task automatic set_regs(logic [31:0] fv, logic [31:0] vc, logic [31:0] rc,
                          logic [31:0] base);
    drain();
    set_reg(CFG_FIRST, fv);
    set_reg(CFG_COUNT, vc);
    set_reg(CFG_ROOTS, rc);
    set_reg(CFG_BASE, base);
  endtask

  // row starts 1..n relative to row_starts[0]; with alt, every other row holds 256 neighbours
  task automatic fill_rows(int n, bit alt);
    int i;
    for (i = 1; i <= n; i++)
      issue(mk(FN_WRITE, SP_RS, i,
               row_v[0] + (alt ? (i % 2) * 256 : $urandom_range(0, 40))));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  task automatic test_setup();
    int i;
    for (i = 0; i < N_WORDS; i++)
      issue(mk(FN_WRITE, SP_SEL, i, (i < 5) ? 32'hFFFF_FFFF : $urandom));
    issue(mk(FN_WRITE, SP_RS, 0, $urandom));
    fill_rows(72, 0);
    for (i = 0; i < 256; i++)
      issue(mk(FN_WRITE, SP_NBR, i, {$urandom_range(0, 'hFFFFF), 6'd0,
                                     6'($urandom_range(0, 63))}));
    for (i = 0; i < 64; i++)
      issue(mk(FN_WRITE, SP_NID, i, $urandom));
    for (i = 0; i < N_ROOTS; i++)
      issue(mk(FN_WRITE, SP_ROOT, i, $urandom_range(0, 63)));
  endtask

  task automatic test_access();
    issue(mk(FN_WRITE, SP_SEL, 127, 32'hFFFF_FFFF));
    issue(mk(FN_READ, SP_SEL, 127, 0));
    issue(mk(FN_WRITE, SP_SEL, 127, 32'd0));
    issue(mk(FN_READ, SP_SEL, 127, 32'hFFFF_FFFF));
    issue(mk(FN_READ, SP_ORS, 16383, 0));
    issue(mk(FN_WRITE, SP_ROOT, 16383, 32'hFFFF_FFFF));
    issue(mk(FN_WRITE, SP_NID, 4095, 32'hFFFF_FFFF));
    issue(mk(FN_READ, SP_NID, 4095, 0));
    issue(mk(3'd6, SP_ROOT, 16383, 32'hFFFF_FFFF));
    issue(mk(3'd7, SP_SEL, 0, 0));
    issue(mk(FN_WRITE, SP_INV, 5, $urandom));
    issue(mk(FN_READ, SP_INV, 5, 0));
    issue(mk(FN_READ, SP_RS, 0, 0));
    issue(mk(FN_CLEAR, SP_SEL, 0, 0));
    issue(mk(FN_READ, SP_INV, 5, 0));
  endtask

  task automatic test_runs();
    // normal flow over a small partition
    set_regs(0, 40, 256, 32'hFFFF_FFFF);
    issue(mk(FN_CLEAR, 0, 0, 0));
    issue(mk(FN_MARK, 0, 0, 0));
    issue(mk(FN_RENUM, 0, 0, 0));
    issue(mk(FN_REBUILD, 0, 0, 0));
    issue(mk(FN_READ, SP_ORS, 0, 0));
    issue(mk(FN_READ, SP_ONBR, 0, 0));
    issue(mk(FN_READ, SP_ROOT, 0, 0));
    // partition running past the last vertex
    set_regs(4095, 4096, 256, 0);
    issue(mk(FN_MARK, 0, 0, 0));
    issue(mk(FN_REBUILD, 0, 0, 0));
    issue(mk(FN_RENUM, 0, 0, 0));
    // renumber span and root count past the stores
    set_regs(0, 8191, 511, 0);
    issue(mk(FN_RENUM, 0, 0, 0));
    // a selected row whose edges start past the edge store
    set_regs(0, 2, 0, 32'h1234_5678);
    issue(mk(FN_WRITE, SP_SEL, 0, 32'h2));
    issue(mk(FN_WRITE, SP_RS, 1, row_v[0] + 16389));
    issue(mk(FN_WRITE, SP_RS, 2, row_v[0] + 16393));
    issue(mk(FN_CLEAR, 0, 0, 0));
    issue(mk(FN_MARK, 0, 0, 0));
    issue(mk(FN_REBUILD, 0, 0, 0));
    issue(mk(FN_WRITE, SP_SEL, 0, 32'hFFFF_FFFF));
    fill_rows(72, 0);
  endtask

  // rows revisit the same 256 neighbour entries until the edge store fills
  task automatic test_overflow();
    set_regs(0, 130, 0, $urandom);
    fill_rows(130, 1);
    issue(mk(FN_CLEAR, 0, 0, 0));
    issue(mk(FN_MARK, 0, 0, 0));
    issue(mk(FN_REBUILD, 0, 0, 0));
    issue(mk(FN_READ, SP_ONBR, 16383, 0));
    issue(mk(FN_READ, SP_ORS, 64, 0));
    fill_rows(130, 0);
  endtask

  function automatic cmd_t rand_access(logic [2:0] fn);
    cmd_t c;
    int depth, win;
    c.fn = fn;
    c.sp = $urandom_range(0, 7);
    c.data = $urandom;
    depth = depth_of(c.sp);
    case (c.sp)
      SP_RS, SP_ORS:   win = 72;
      SP_NBR, SP_ROOT: win = 255;
      SP_ONBR:         win = 300;
      default:         win = 127;
    endcase
    if ($urandom_range(0, 19) == 0)
      c.idx = (depth < N_EDGES) ? $urandom_range(depth, 16383) : $urandom_range(0, 16383);
    else
      c.idx = $urandom_range(0, win);
    if (fn == FN_WRITE) begin
      if (c.sp == SP_RS && c.idx <= win)
        c.data = (c.idx == 0) ? row_v[0] - $urandom_range(0, 8)
                              : row_v[0] + $urandom_range(0, 40);
      if ((c.sp == SP_NBR || c.sp == SP_ROOT) && $urandom_range(0, 29) != 0)
        c.data[11:0] = $urandom_range(0, 63);
    end
    return c;
  endfunction

  task automatic random_item();
    int p;
    logic [2:0] fn;
    p = $urandom_range(0, 99);
    if (p < 32) issue(rand_access(FN_WRITE));
    else if (p < 64) issue(rand_access(FN_READ));
    else if (p < 68) issue(mk(FN_CLEAR, $urandom, $urandom, $urandom));
    else if (p < 70) issue(mk($urandom_range(6, 7), $urandom, $urandom, $urandom));
    else if (p < 85) begin
      case ($urandom_range(0, 2))
        0:       fn = FN_MARK;
        1:       fn = FN_RENUM;
        default: fn = FN_REBUILD;
      endcase
      issue(mk(fn, $urandom, $urandom, $urandom));
    end else begin
      // full compaction pass, then look at its output
      issue(mk(FN_CLEAR, 0, 0, 0));
      issue(mk(FN_MARK, 0, 0, 0));
      issue(mk(FN_RENUM, 0, 0, 0));
      issue(mk(FN_REBUILD, 0, 0, 0));
      issue(mk(FN_READ, SP_ORS, $urandom_range(0, 8), 0));
      issue(mk(FN_READ, SP_ONBR, $urandom_range(0, 40), 0));
    end
  endtask

  task automatic test_random();
    int ph, n;
    int gaps [5] = '{0, 47, 0, 20, 47};
    for (ph = 0; ph < 5; ph++) begin
      if (ph == 2) set_regs(0, 0, 0, 0);
      else set_regs(($urandom_range(0, 3) == 0) ? 4095 - $urandom_range(0, 20)
                                                : $urandom_range(0, 200),
                    $urandom_range(0, 64), $urandom_range(0, 256), $urandom);
      gap_pct = gaps[ph];
      for (n = 0; n < 250; n++) random_item();
    end
    gap_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // result checking
  task automatic field_err(string name, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected 0x%0h, got 0x%0h", name, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      got_r = {out_read_value, out_out_rows, out_out_edges, out_status};
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result word with nothing expected: 0x%0h", got_r);
      end else begin
        want_r = pending.pop_front();
        if (got_r.rv !== want_r.rv) field_err("read_value", want_r.rv, got_r.rv);
        if (got_r.rows !== want_r.rows) field_err("out_rows", want_r.rows, got_r.rows);
        if (got_r.edges !== want_r.edges) field_err("out_edges", want_r.edges, got_r.edges);
        if (got_r.st !== want_r.st) field_err("status", want_r.st, got_r.st);
      end
    end
  end

  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("csr_subgraph_compactor_test: done, errors");
    $finish;
  end

  initial begin
    int i;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = '0;
    in_space = '0;
    in_index = '0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    gap_pct = 0;
    probing = 1'b0;
    reg_first = 0;
    reg_count = 0;
    reg_roots = 0;
    reg_base = 0;
    rows_total = 0;
    edges_total = 0;
    for (i = 0; i < N_WORDS; i++) begin
      inv_v[i] = 0;
      known[SP_INV][i] = 1'b1;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_setup();
    test_access();
    test_runs();
    test_overflow();
    test_random();

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending.size() == 0)
      $display("csr_subgraph_compactor_test: done, clean");
    else
      $display("csr_subgraph_compactor_test: done, errors");
    $finish;
  end

endmodule
